[rtl/c8alu_pkg.sv]
package c8alu_pkg;

  localparam logic [3:0] KIND_INC8  = 4'd0;
  localparam logic [3:0] KIND_DEC8  = 4'd1;
  localparam logic [3:0] KIND_INC16 = 4'd2;
  localparam logic [3:0] KIND_DEC16 = 4'd3;
  localparam logic [3:0] KIND_ADD   = 4'd4;
  localparam logic [3:0] KIND_ADC   = 4'd5;
  localparam logic [3:0] KIND_SUB   = 4'd6;
  localparam logic [3:0] KIND_SBC   = 4'd7;
  localparam logic [3:0] KIND_CP    = 4'd8;
  localparam logic [3:0] KIND_AND   = 4'd9;
  localparam logic [3:0] KIND_OR    = 4'd10;
  localparam logic [3:0] KIND_XOR   = 4'd11;
  localparam logic [3:0] KIND_ADDHL = 4'd12;
  localparam logic [3:0] KIND_ADDSP = 4'd13;

  localparam logic [3:0] SRC_A      = 4'd0;
  localparam logic [3:0] SRC_HL_MEM = 4'd7;
  localparam logic [3:0] SRC_IMM    = 4'd8;

  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;
  localparam logic [1:0] PAIR_HL = 2'd2;
  localparam logic [1:0] PAIR_SP = 2'd3;

  localparam logic [2:0] REG_A = 3'd0;
  localparam logic [2:0] REG_B = 3'd1;
  localparam logic [2:0] REG_C = 3'd2;
  localparam logic [2:0] REG_D = 3'd3;
  localparam logic [2:0] REG_E = 3'd4;
  localparam logic [2:0] REG_H = 3'd5;
  localparam logic [2:0] REG_L = 3'd6;

  localparam int unsigned NUM_REGS = 7;

  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  typedef struct packed {
    logic [3:0] kind;
    logic [3:0] source_select;
    logic [1:0] pair_select;
    logic [7:0] memory_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  accumulator;
    logic [3:0]  flag_bits;
    logic [15:0] hl_address;
    logic [15:0] stack_pointer;
    logic        mem_write;
    logic [7:0]  mem_write_data;
    logic        immediate_used;
    logic        illegal;
  } out_item_t;

endpackage

[rtl/cpu8_alu_with_flags.sv]
// 8-bit CPU ALU with register file (A,B,C,D,E,H,L), stack pointer and Z/N/H/C flags.
// Input channel: in_valid_i / in_stall_o / in_data_i, one instruction per transfer.
// Output channel: out_valid_o / out_stall_i / out_data_o, one result per instruction.
// Bytes read at [HL] or immediates come in memory_byte; write-back to [HL] leaves
// as mem_write / mem_write_data in the result.
// An accepted transfer is held in the input register and moves into the result
// register, which drives out_data_o, once the result register is free or being drained.
// Throughput: one instruction per cycle while out_stall_i is low; the register
// file updates when the instruction moves from the input register into the
// result register, so the next instruction always sees the updated state.
// Reset clears A..L, SP, flags and both valid bits.
// When the receiver stalls, the result register holds, the input register fills
// and then in_stall_o rises; nothing is lost or repeated.
// Illegal kind/selector combinations set illegal and leave all state unchanged.
module cpu8_alu_with_flags (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  c8alu_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output c8alu_pkg::out_item_t out_data_o
);
  import c8alu_pkg::*;

  in_item_t    in_q;
  logic        in_valid_q;
  out_item_t   out_q, out_d;
  logic        out_valid_q;
  logic [7:0]  regs_q [NUM_REGS];
  logic [7:0]  regs_d [NUM_REGS];
  logic [15:0] sp_q, sp_d;
  logic [3:0]  flags_q, flags_d;
  logic        advance, accept;

  logic [7:0]  a, opnd, old8, new8, res8;
  logic        cin, c_use;
  logic [8:0]  sum9, dif9;
  logic [4:0]  hsum5, hdif5;
  logic [15:0] pair_v, hl_v;
  logic [16:0] hl_sum;
  logic [12:0] hl_hsum;
  logic [4:0]  sp_h;
  logic [8:0]  sp_c;
  logic [3:0]  f;
  logic        ill, mw, imm;
  logic [7:0]  mwd;
  logic [15:0] pair_new;
  logic        pair_wr;
  logic [1:0]  pair_dst;

  function automatic logic [7:0] rd_byte(input logic [7:0] r [NUM_REGS],
                                         input logic [3:0] s);
    logic [7:0] v;
    v = 8'h00;
    case (s[2:0])
      REG_A:   v = r[REG_A];
      REG_B:   v = r[REG_B];
      REG_C:   v = r[REG_C];
      REG_D:   v = r[REG_D];
      REG_E:   v = r[REG_E];
      REG_H:   v = r[REG_H];
      REG_L:   v = r[REG_L];
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    a      = regs_q[REG_A];
    cin    = flags_q[FLAG_C];
    hl_v   = {regs_q[REG_H], regs_q[REG_L]};
    case (in_q.pair_select)
      PAIR_BC: pair_v = {regs_q[REG_B], regs_q[REG_C]};
      PAIR_DE: pair_v = {regs_q[REG_D], regs_q[REG_E]};
      PAIR_HL: pair_v = hl_v;
      default: pair_v = sp_q;
    endcase

    old8  = (in_q.source_select == SRC_HL_MEM) ? in_q.memory_byte
                                               : rd_byte(regs_q, in_q.source_select);
    opnd  = (in_q.source_select >= SRC_HL_MEM) ? in_q.memory_byte
                                               : rd_byte(regs_q, in_q.source_select);
    c_use = ((in_q.kind == KIND_ADC) || (in_q.kind == KIND_SBC)) ? cin : 1'b0;
    sum9  = {1'b0, a} + {1'b0, opnd} + {8'h00, c_use};
    dif9  = {1'b0, a} - {1'b0, opnd} - {8'h00, c_use};
    hsum5 = {1'b0, a[3:0]} + {1'b0, opnd[3:0]} + {4'h0, c_use};
    hdif5 = {1'b0, a[3:0]} - {1'b0, opnd[3:0]} - {4'h0, c_use};
    new8  = (in_q.kind == KIND_INC8) ? old8 + 8'd1 : old8 - 8'd1;

    hl_sum  = {1'b0, hl_v} + {1'b0, pair_v};
    hl_hsum = {1'b0, hl_v[11:0]} + {1'b0, pair_v[11:0]};
    sp_h    = {1'b0, sp_q[3:0]} + {1'b0, in_q.memory_byte[3:0]};
    sp_c    = {1'b0, sp_q[7:0]} + {1'b0, in_q.memory_byte};

    regs_d   = regs_q;
    sp_d     = sp_q;
    f        = flags_q;
    ill      = 1'b0;
    mw       = 1'b0;
    mwd      = 8'h00;
    imm      = 1'b0;
    res8     = a;
    pair_wr  = 1'b0;
    pair_dst = in_q.pair_select;
    pair_new = pair_v;

    case (in_q.kind) inside
      KIND_INC8, KIND_DEC8: begin
        if (in_q.source_select > SRC_HL_MEM) begin
          ill = 1'b1;
        end else begin
          f[FLAG_Z] = (new8 == 8'h00);
          f[FLAG_N] = (in_q.kind == KIND_DEC8);
          f[FLAG_H] = (in_q.kind == KIND_INC8) ? (old8[3:0] == 4'hf)
                                               : (old8[3:0] == 4'h0);
          if (in_q.source_select == SRC_HL_MEM) begin
            mw  = 1'b1;
            mwd = new8;
          end else begin
            regs_d[in_q.source_select[2:0]] = new8;
          end
        end
      end
      KIND_INC16: begin
        pair_wr  = 1'b1;
        pair_new = pair_v + 16'd1;
      end
      KIND_DEC16: begin
        pair_wr  = 1'b1;
        pair_new = pair_v - 16'd1;
      end
      [KIND_ADD:KIND_XOR]: begin
        if (in_q.source_select > SRC_IMM) begin
          ill = 1'b1;
        end else begin
          imm = (in_q.source_select == SRC_IMM);
          case (in_q.kind) inside
            KIND_ADD, KIND_ADC: begin
              res8 = sum9[7:0];
              f    = {sum9[7:0] == 8'h00, 1'b0, hsum5[4], sum9[8]};
            end
            KIND_SUB, KIND_SBC, KIND_CP: begin
              if (in_q.kind != KIND_CP) res8 = dif9[7:0];
              f = {dif9[7:0] == 8'h00, 1'b1, hdif5[4], dif9[8]};
            end
            KIND_AND: begin
              res8 = a & opnd;
              f    = {(a & opnd) == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            KIND_OR: begin
              res8 = a | opnd;
              f    = {(a | opnd) == 8'h00, 1'b0, 1'b0, 1'b0};
            end
            default: begin
              res8 = a ^ opnd;
              f    = {(a ^ opnd) == 8'h00, 1'b0, 1'b0, 1'b0};
            end
          endcase
          regs_d[REG_A] = res8;
        end
      end
      KIND_ADDHL: begin
        pair_wr   = 1'b1;
        pair_dst  = PAIR_HL;
        pair_new  = hl_sum[15:0];
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = hl_hsum[12];
        f[FLAG_C] = hl_sum[16];
      end
      KIND_ADDSP: begin
        imm  = 1'b1;
        f    = {1'b0, 1'b0, sp_h[4], sp_c[8]};
        sp_d = sp_q + {{8{in_q.memory_byte[7]}}, in_q.memory_byte};
      end
      default: ill = 1'b1;
    endcase

    if (pair_wr) begin
      case (pair_dst)
        PAIR_BC: begin
          regs_d[REG_B] = pair_new[15:8];
          regs_d[REG_C] = pair_new[7:0];
        end
        PAIR_DE: begin
          regs_d[REG_D] = pair_new[15:8];
          regs_d[REG_E] = pair_new[7:0];
        end
        PAIR_HL: begin
          regs_d[REG_H] = pair_new[15:8];
          regs_d[REG_L] = pair_new[7:0];
        end
        default: sp_d = pair_new;
      endcase
    end

    flags_d = ill ? flags_q : f;

    out_d.accumulator    = regs_d[REG_A];
    out_d.flag_bits      = flags_d;
    out_d.hl_address     = {regs_d[REG_H], regs_d[REG_L]};
    out_d.stack_pointer  = sp_d;
    out_d.mem_write      = mw;
    out_d.mem_write_data = mwd;
    out_d.immediate_used = imm;
    out_d.illegal        = ill;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sp_q        <= 16'h0000;
      flags_q     <= 4'h0;
      regs_q      <= '{default: 8'h00};
    end else begin
      in_valid_q  <= accept || (in_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && out_stall_i);
      if (advance) begin
        regs_q  <= regs_d;
        sp_q    <= sp_d;
        flags_q <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
    if (advance) out_q <= out_d;
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import c8alu_pkg::*;

  localparam logic [3:0] KIND_BAD_LO = 4'd14;
  localparam logic [3:0] KIND_BAD_HI = 4'd15;
  localparam logic [3:0] SRC_B       = {1'b0, REG_B};
  localparam logic [3:0] SRC_C       = {1'b0, REG_C};
  localparam logic [3:0] SRC_H       = {1'b0, REG_H};
  localparam logic [3:0] SRC_L       = {1'b0, REG_L};
  localparam logic [3:0] SRC_BAD_LO  = 4'd9;
  localparam logic [3:0] SRC_BAD_HI  = 4'd15;

  localparam int N_DIRECTED      = 27;
  localparam int N_RANDOM        = 1850;
  localparam int PRESSURE_AT     = 300;
  localparam int PRESSURE_CYCLES = 150;
  localparam int DRAIN_CYCLES    = 8;

  typedef struct packed {
    in_item_t  op;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  localparam out_item_t NOT_TYPED = '0;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  logic [7:0]  byte_file [NUM_REGS];
  logic [15:0] sp_model;
  logic [3:0]  flag_model;
  out_item_t   predicted_results [$];
  out_item_t   oldest;
  int          mismatches = 0;

  cpu8_alu_with_flags dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #5000000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic logic [15:0] get_pair(input logic [1:0] sel);
    case (sel)
      PAIR_BC: return {byte_file[REG_B], byte_file[REG_C]};
      PAIR_DE: return {byte_file[REG_D], byte_file[REG_E]};
      PAIR_HL: return {byte_file[REG_H], byte_file[REG_L]};
      default: return sp_model;
    endcase
  endfunction

  function automatic void put_pair(input logic [1:0] sel, input logic [15:0] val);
    case (sel)
      PAIR_BC: {byte_file[REG_B], byte_file[REG_C]} = val;
      PAIR_DE: {byte_file[REG_D], byte_file[REG_E]} = val;
      PAIR_HL: {byte_file[REG_H], byte_file[REG_L]} = val;
      default: sp_model = val;
    endcase
  endfunction

  task automatic predict_alu(input in_item_t op, output out_item_t res);
    logic [7:0]  a, v, old, nv;
    logic [3:0]  f;
    logic [8:0]  s9;
    logic [4:0]  s5;
    logic [16:0] s17;
    logic [12:0] s13;
    logic [15:0] hl, rr;
    logic        c;
    logic        bad;
    res = '0;
    a = byte_file[REG_A];
    f = flag_model;
    c = 1'b0;
    bad = 1'b0;
    case (op.kind) inside
      KIND_INC8, KIND_DEC8: begin
        if (op.source_select > SRC_HL_MEM) begin
          bad = 1'b1;
        end else begin
          old = (op.source_select == SRC_HL_MEM) ? op.memory_byte
                                                 : byte_file[op.source_select[2:0]];
          if (op.kind == KIND_INC8) begin
            nv = old + 8'd1;
            f[FLAG_N] = 1'b0;
            f[FLAG_H] = (old[3:0] == 4'hf);
          end else begin
            nv = old - 8'd1;
            f[FLAG_N] = 1'b1;
            f[FLAG_H] = (old[3:0] == 4'h0);
          end
          f[FLAG_Z] = (nv == 8'd0);
          if (op.source_select == SRC_HL_MEM) begin
            res.mem_write = 1'b1;
            res.mem_write_data = nv;
          end else begin
            byte_file[op.source_select[2:0]] = nv;
          end
        end
      end
      KIND_INC16: put_pair(op.pair_select, get_pair(op.pair_select) + 16'd1);
      KIND_DEC16: put_pair(op.pair_select, get_pair(op.pair_select) - 16'd1);
      [KIND_ADD:KIND_XOR]: begin
        if (op.source_select > SRC_IMM) begin
          bad = 1'b1;
        end else begin
          v = (op.source_select >= SRC_HL_MEM) ? op.memory_byte
                                               : byte_file[op.source_select[2:0]];
          res.immediate_used = (op.source_select == SRC_IMM);
          if (op.kind == KIND_ADC || op.kind == KIND_SBC) c = flag_model[FLAG_C];
          case (op.kind) inside
            KIND_ADD, KIND_ADC: begin
              s9 = {1'b0, a} + {1'b0, v} + {8'h00, c};
              s5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'h0, c};
              f = {s9[7:0] == 8'd0, 1'b0, s5[4], s9[8]};
              a = s9[7:0];
            end
            KIND_SUB, KIND_SBC, KIND_CP: begin
              s9 = {1'b0, a} - {1'b0, v} - {8'h00, c};
              s5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'h0, c};
              f = {s9[7:0] == 8'd0, 1'b1, s5[4], s9[8]};
              if (op.kind != KIND_CP) a = s9[7:0];
            end
            KIND_AND: begin
              a = a & v;
              f = {a == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            KIND_OR: begin
              a = a | v;
              f = {a == 8'd0, 3'b000};
            end
            default: begin
              a = a ^ v;
              f = {a == 8'd0, 3'b000};
            end
          endcase
          byte_file[REG_A] = a;
        end
      end
      KIND_ADDHL: begin
        hl = get_pair(PAIR_HL);
        rr = get_pair(op.pair_select);
        s17 = {1'b0, hl} + {1'b0, rr};
        s13 = {1'b0, hl[11:0]} + {1'b0, rr[11:0]};
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = s13[12];
        f[FLAG_C] = s17[16];
        put_pair(PAIR_HL, s17[15:0]);
      end
      KIND_ADDSP: begin
        res.immediate_used = 1'b1;
        s5 = {1'b0, sp_model[3:0]} + {1'b0, op.memory_byte[3:0]};
        s9 = {1'b0, sp_model[7:0]} + {1'b0, op.memory_byte};
        f = {2'b00, s5[4], s9[8]};
        sp_model = sp_model + {{8{op.memory_byte[7]}}, op.memory_byte};
      end
      default: bad = 1'b1;
    endcase
    if (!bad) flag_model = f;
    res.accumulator   = byte_file[REG_A];
    res.flag_bits     = flag_model;
    res.hl_address    = get_pair(PAIR_HL);
    res.stack_pointer = sp_model;
    res.illegal       = bad;
  endtask

  function automatic in_item_t random_op();
    in_item_t op;
    int       r;
    r = $urandom_range(0, 99);
    op.pair_select = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0: op.memory_byte = 8'h00;
      1: op.memory_byte = 8'hff;
      2: op.memory_byte = 8'h0f;
      3: op.memory_byte = 8'h10;
      4: op.memory_byte = 8'h80;
      5: op.memory_byte = 8'h7f;
      default: op.memory_byte = 8'($urandom_range(0, 255));
    endcase
    if (r < 4) begin
      op.kind = 4'($urandom_range(KIND_BAD_LO, KIND_BAD_HI));
      op.source_select = 4'($urandom_range(0, 15));
    end else if (r < 8) begin
      op.kind = 4'($urandom_range(KIND_INC8, KIND_DEC8));
      op.source_select = 4'($urandom_range(SRC_IMM, SRC_BAD_HI));
    end else if (r < 12) begin
      op.kind = 4'($urandom_range(KIND_ADD, KIND_XOR));
      op.source_select = 4'($urandom_range(SRC_BAD_LO, SRC_BAD_HI));
    end else begin
      op.kind = 4'($urandom_range(KIND_INC8, KIND_ADDSP));
      if (op.kind <= KIND_DEC8) op.source_select = 4'($urandom_range(SRC_A, SRC_HL_MEM));
      else op.source_select = 4'($urandom_range(SRC_A, SRC_IMM));
    end
    return op;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  task automatic check_result(input out_item_t got, input out_item_t want);
    if (got.accumulator !== want.accumulator)
      report_mismatch("accumulator", 16'(got.accumulator), 16'(want.accumulator));
    if (got.flag_bits !== want.flag_bits)
      report_mismatch("flag_bits", 16'(got.flag_bits), 16'(want.flag_bits));
    if (got.hl_address !== want.hl_address)
      report_mismatch("hl_address", got.hl_address, want.hl_address);
    if (got.stack_pointer !== want.stack_pointer)
      report_mismatch("stack_pointer", got.stack_pointer, want.stack_pointer);
    if (got.mem_write !== want.mem_write)
      report_mismatch("mem_write", 16'(got.mem_write), 16'(want.mem_write));
    if (got.mem_write_data !== want.mem_write_data)
      report_mismatch("mem_write_data", 16'(got.mem_write_data),
                      16'(want.mem_write_data));
    if (got.immediate_used !== want.immediate_used)
      report_mismatch("immediate_used", 16'(got.immediate_used),
                      16'(want.immediate_used));
    if (got.illegal !== want.illegal)
      report_mismatch("illegal", 16'(got.illegal), 16'(want.illegal));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_results.size() == 0) begin
        report_mismatch("result with nothing pending", '0, '0);
      end else begin
        oldest = predicted_results.pop_front();
        check_result(out_data_o, oldest);
      end
    end
  end

  initial begin : result_sink
    int hold;
    int taken;
    bit calm;
    taken = 0;
    calm = 1'b0;
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (taken == PRESSURE_AT) hold = PRESSURE_CYCLES;
      else hold = calm ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  initial begin : stimulus
    dir_row_t  rows [N_DIRECTED];
    in_item_t  op;
    out_item_t want;
    int        gap;
    bit        calm;
    rows = '{
      {{KIND_BAD_HI, SRC_A, PAIR_BC, 8'h00}, 1'b1,
       {8'h00, 4'b0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b1}},
      {{KIND_INC8, SRC_IMM, PAIR_BC, 8'hff}, 1'b1,
       {8'h00, 4'b0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b1}},
      {{KIND_ADD, SRC_BAD_LO, PAIR_BC, 8'hff}, 1'b1,
       {8'h00, 4'b0000, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b1}},
      {{KIND_DEC8, SRC_A, PAIR_BC, 8'h00}, 1'b1,
       {8'hff, 4'b0110, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0}},
      {{KIND_INC8, SRC_A, PAIR_BC, 8'h00}, 1'b1,
       {8'h00, 4'b1010, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0, 1'b0}},
      {{KIND_DEC16, SRC_A, PAIR_BC, 8'h00}, 1'b0, NOT_TYPED},
      {{KIND_INC16, SRC_A, PAIR_SP, 8'h00}, 1'b0, NOT_TYPED},
      {{KIND_DEC8, SRC_HL_MEM, PAIR_BC, 8'h00}, 1'b0, NOT_TYPED},
      {{KIND_INC8, SRC_HL_MEM, PAIR_BC, 8'hff}, 1'b0, NOT_TYPED},
      {{KIND_ADD, SRC_IMM, PAIR_BC, 8'hff}, 1'b0, NOT_TYPED},
      {{KIND_ADC, SRC_IMM, PAIR_DE, 8'h01}, 1'b0, NOT_TYPED},
      {{KIND_ADC, SRC_B, PAIR_BC, 8'h00}, 1'b0, NOT_TYPED},
      {{KIND_SUB, SRC_IMM, PAIR_BC, 8'h01}, 1'b0, NOT_TYPED},
      {{KIND_SBC, SRC_C, PAIR_BC, 8'h00}, 1'b0, NOT_TYPED},
      {{KIND_CP, SRC_HL_MEM, PAIR_BC, 8'h80}, 1'b0, NOT_TYPED},
      {{KIND_AND, SRC_IMM, PAIR_BC, 8'h0f}, 1'b0, NOT_TYPED},
      {{KIND_OR, SRC_IMM, PAIR_BC, 8'hf0}, 1'b0, NOT_TYPED},
      {{KIND_XOR, SRC_A, PAIR_BC, 8'h00}, 1'b0, NOT_TYPED},
      {{KIND_INC8, SRC_H, PAIR_BC, 8'h00}, 1'b0, NOT_TYPED},
      {{KIND_DEC8, SRC_L, PAIR_BC, 8'h00}, 1'b0, NOT_TYPED},
      {{KIND_ADDHL, SRC_A, PAIR_BC, 8'h00}, 1'b0, NOT_TYPED},
      {{KIND_ADDHL, SRC_A, PAIR_HL, 8'h00}, 1'b0, NOT_TYPED},
      {{KIND_ADDHL, SRC_A, PAIR_SP, 8'h00}, 1'b0, NOT_TYPED},
      {{KIND_ADDSP, SRC_A, PAIR_BC, 8'h80}, 1'b0, NOT_TYPED},
      {{KIND_ADDSP, SRC_A, PAIR_BC, 8'h7f}, 1'b0, NOT_TYPED},
      {{KIND_BAD_LO, SRC_BAD_HI, PAIR_SP, 8'haa}, 1'b0, NOT_TYPED},
      {{KIND_DEC8, SRC_BAD_HI, PAIR_DE, 8'h55}, 1'b0, NOT_TYPED}
    };
    foreach (byte_file[i]) byte_file[i] = '0;
    sp_model = '0;
    flag_model = '0;
    calm = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    for (int n = 0; n < N_DIRECTED + N_RANDOM; n++) begin
      if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 5);
      if (n < N_DIRECTED) op = rows[n].op;
      else op = random_op();
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= op;
      do @(posedge clk_i); while (in_stall_o);
      // transfer taken at this edge
      predict_alu(op, want);
      if (n < N_DIRECTED && rows[n].typed) want = rows[n].want;
      predicted_results.push_back(want);
    end
    in_valid_i <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[cpu8_alu_with_flags.f]
rtl/c8alu_pkg.sv
rtl/cpu8_alu_with_flags.sv
dv/testbench.sv
